@@ rtl/core/pdsel_pkg.sv @@
// pdsel_pkg: shared types and constants for the power data object selector
// used by pdsel_div, pdsel_dp, pdsel_ctrl and pd_source_offer_selector
`default_nettype none

package pdsel_pkg;

  // list and arithmetic constants
  localparam int MAX_OFFERS     = 8;
  localparam int POWER_LIMIT_W  = 140;
  localparam int CURRENT_CAP_MA = 10230;
  localparam int FIXED_DIVISOR  = 1000000;
  localparam int DIV_STEPS      = 13;

  // power data object kinds, bits 31:30
  typedef enum logic [1:0] {
    PDO_FIXED     = 2'd0,
    PDO_BATTERY   = 2'd1,
    PDO_VARIABLE  = 2'd2,
    PDO_AUGMENTED = 2'd3
  } pdo_kind_t;

  // configuration register indexes
  typedef enum logic {
    CFG_MIN_POWER   = 1'b0,
    CFG_MAX_VOLTAGE = 1'b1
  } cfg_index_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_JUDGE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture the incoming beat
    logic mul;        // register product and selected voltage
    logic div_start;  // load the divider
    logic emit;       // write the result register
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic pos_zero;   // captured position is zero
    logic last;       // captured object ends the list
    logic match;      // captured object meets the limits
    logic div_done;   // divider is on its final step
    logic out_free;   // result register can take a new beat
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/pdsel_div.sv @@
// pdsel_div: restoring divider, one quotient bit per cycle
// depends on pdsel_pkg for the step count
`default_nettype none

module pdsel_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [28:0] dividend,
  input  wire logic [19:0] divisor,
  output logic             done,
  output logic [12:0]      quotient
);
  import pdsel_pkg::*;

  logic        busy;
  logic [3:0]  cnt;
  logic [28:0] rem;
  logic [31:0] dsh;
  logic        fits;

  // trial subtraction against the shifted divisor
  assign fits = ({3'd0, rem} >= dsh);
  assign done = busy && (cnt == 4'd1);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 4'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 4'(DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 4'd1;
      if (cnt == 4'd1) begin
        busy <= 1'b0;
      end
    end
  end

  // remainder, divisor and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsh      <= {divisor, 12'd0};
      quotient <= 13'd0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh[28:0];
      end
      quotient <= {quotient[11:0], fits};
      dsh      <= {1'b0, dsh[31:1]};
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pdsel_dp.sv @@
// pdsel_dp: datapath with object decode, multiplier, divider, limit checks,
// configuration registers and result register; uses pdsel_pkg and pdsel_div
`default_nettype none

module pdsel_dp (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire pdsel_pkg::dp_cmd_t     cmd,
  output pdsel_pkg::dp_status_t       status,
  input  wire logic [39:0]            s_tdata,
  input  wire logic                   s_tlast,
  input  wire logic                   cfg_valid,
  input  wire logic                   cfg_index,
  input  wire logic [15:0]            cfg_data,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [47:0]                 m_tdata,
  output logic                        m_tuser
);
  import pdsel_pkg::*;

  logic [7:0]  watt_floor;
  logic [15:0] max_voltage;

  logic [31:0] word;
  logic [2:0]  pos;
  logic        last;
  logic [1:0]  kind;

  logic [15:0] fx_mv;
  logic [13:0] fx_ma;
  logic [15:0] bt_mv;
  logic [7:0]  bt_w;

  logic [15:0] mv;
  logic [28:0] prod;
  logic [19:0] divisor;
  logic        div_done;
  logic [12:0] quo;

  logic        usable;
  logic [9:0]  power;
  logic [13:0] current;
  logic        match;

  logic [2:0]  res_index;
  logic [15:0] res_mv;
  logic [13:0] res_ma;
  logic [9:0]  res_w;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      watt_floor  <= 8'd1;
      max_voltage <= 16'd20000;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MIN_POWER:   watt_floor  <= cfg_data[7:0];
        CFG_MAX_VOLTAGE: max_voltage <= cfg_data;
      endcase
    end
  end

  // capture the incoming beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word <= s_tdata[31:0];
      pos  <= s_tdata[34:32];
      last <= s_tlast;
    end
  end

  // field decode
  assign kind  = word[31:30];
  assign fx_mv = 16'(word[19:10]) * 16'd50;
  assign fx_ma = 14'(word[9:0]) * 14'd10;
  assign bt_mv = 16'(word[29:20]) * 16'd50;
  assign bt_w  = word[9:2];

  // product stage: mv*ma for fixed, watts*1000 for battery
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      if (kind == PDO_FIXED) begin
        mv   <= fx_mv;
        prod <= {13'd0, fx_mv} * {15'd0, fx_ma};
      end else begin
        mv   <= (kind == PDO_BATTERY) ? bt_mv : 16'd0;
        prod <= {21'd0, bt_w} * 29'd1000;
      end
    end
  end

  assign divisor = (kind == PDO_FIXED) ? 20'(FIXED_DIVISOR) : {4'd0, mv};

  pdsel_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quo)
  );

  // offer values and limit checks
  always_comb begin
    usable  = (kind == PDO_FIXED) || (kind == PDO_BATTERY);
    power   = 10'd0;
    current = 14'd0;
    if (kind == PDO_FIXED) begin
      power   = quo[9:0];
      current = fx_ma;
    end else if (kind == PDO_BATTERY) begin
      power = {2'd0, bt_w};
      if (mv != 16'd0) begin
        current = ({1'b0, quo} > 14'(CURRENT_CAP_MA)) ? 14'(CURRENT_CAP_MA) : {1'b0, quo};
      end
    end
    match = usable
         && ({29'd0, pos} < 32'(MAX_OFFERS))
         && (watt_floor != 8'd0)
         && (watt_floor <= 8'(POWER_LIMIT_W))
         && (power >= {2'd0, watt_floor})
         && (mv <= max_voltage);
  end

  // result register, cleared payload on a no-match beat
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tuser   <= match;
      res_index <= match ? pos : 3'd0;
      res_mv    <= match ? mv : 16'd0;
      res_ma    <= match ? current : 14'd0;
      res_w     <= match ? power : 10'd0;
    end
  end

  assign m_tdata = {5'd0, res_w, res_ma, res_mv, res_index};

  assign status.pos_zero = (pos == 3'd0);
  assign status.last     = last;
  assign status.match    = match;
  assign status.div_done = div_done;
  assign status.out_free = !m_tvalid || m_tready;

endmodule

`default_nettype wire

@@ rtl/core/pdsel_ctrl.sv @@
// pdsel_ctrl: controller state machine sequencing capture, multiply, divide
// and decision; holds the search-done flag; uses pdsel_pkg
`default_nettype none

module pdsel_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  output pdsel_pkg::dp_cmd_t          cmd,
  input  wire pdsel_pkg::dp_status_t  status
);
  import pdsel_pkg::*;

  state_t state;
  state_t state_next;
  logic   search_done;
  logic   done_now;
  logic   want_emit;

  // a new list restarts the search before the object is judged
  assign done_now  = search_done && !status.pos_zero;
  assign want_emit = !done_now && (status.match || status.last);

  // state register and search flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      search_done <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_JUDGE && state_next == ST_IDLE) begin
        search_done <= want_emit ? 1'b1 : done_now;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_MUL;
      ST_MUL:    state_next = ST_DSTART;
      ST_DSTART: state_next = ST_DIV;
      ST_DIV:    if (status.div_done) state_next = ST_JUDGE;
      ST_JUDGE:  if (!want_emit || status.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.mul       = 1'b0;
    cmd.div_start = 1'b0;
    cmd.emit      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_MUL:    cmd.mul = 1'b1;
      ST_DSTART: cmd.div_start = 1'b1;
      ST_DIV:    ;
      ST_JUDGE:  cmd.emit = want_emit && status.out_free;
      default:   ;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/pd_source_offer_selector.sv @@
// pd_source_offer_selector: top level joining controller and datapath
// depends on pdsel_pkg, pdsel_ctrl, pdsel_dp and pdsel_div
`default_nettype none

// Takes a USB PD source capability list one power data object per input
// beat and reports the first fixed or battery object whose power reaches
// the minimum power at a voltage no higher than the voltage ceiling, or a
// no-match beat (m_tuser 0, all fields 0) when the list's last object passes
// without one. A position of 0 starts a new search. Each object passes, from
// its acceptance to the taking of the next one, through capture, a multiply
// step, a divider load, 13 iterations of the restoring divider (one quotient
// bit a cycle, shared by the fixed watts and battery current paths) and a
// decision step. The result sits in an output register, so the next object
// is taken while it waits; the decision stalls only if a second result
// arrives before the first is taken. Configuration is always ready.
module pd_source_offer_selector (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // pdo_word[31:0], pdo_index[34:32], zero pad
  input  wire logic        s_tlast,   // last_pdo
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // selected_index[2:0], voltage_mv[18:3],
                                      // current_ma[32:19], power_w[42:33], zero pad
  output logic             m_tuser,   // found
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);
  import pdsel_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  pdsel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  pdsel_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire

@@ tb/tb_pd_source_offer_selector.sv @@
// tb_pd_source_offer_selector: self-checking bench for the pd offer selector
// drives capability lists and limit writes, predicts each selection beat
// depends on pdsel_pkg and pd_source_offer_selector
`timescale 1ns / 100ps

module tb_pd_source_offer_selector;
  import pdsel_pkg::*;

  localparam int OFFER_SLOTS   = 8;
  localparam int POWER_CAP_W   = 140;
  localparam int AMP_CAP_MA    = 10230;
  localparam int IDLE_PCT      = 34;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PHASES        = 12;
  localparam int PHASE_OFFERS  = 125;

  // one selection beat as the block reports it
  typedef struct packed {
    logic        found;
    logic [2:0]  sel;
    logic [15:0] mv;
    logic [13:0] ma;
    logic [9:0]  w;
  } offer_res_t;

  typedef enum logic [1:0] {CHK_MODEL, CHK_QUIET, CHK_TYPED} chk_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  pos;
    logic        last;
    chk_t        chk;
    offer_res_t  res;
  } probe_t;

  localparam offer_res_t NO_MATCH = '0;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata   = '0;
  logic        s_tlast   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data  = '0;

  // predictor copy of the limits and the list state
  logic [7:0]  watt_floor_q = 8'd1;
  logic [15:0] max_mv_q     = 16'd20000;
  logic        list_closed  = 1'b0;

  offer_res_t  expected_offers[$];
  probe_t      probes[$];
  int          mismatches  = 0;
  int          offers_sent = 0;
  int          hold_left   = 0;
  bit          calm        = 1'b0;

  logic [9:0] volts [8] = '{10'd100, 10'd180, 10'd240, 10'd300,
                            10'd400, 10'd560, 10'd720, 10'd960};
  logic [9:0] amps  [8] = '{10'd50, 10'd100, 10'd150, 10'd200,
                            10'd300, 10'd325, 10'd500, 10'd1023};

  pd_source_offer_selector uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic note_error(input string msg);
    mismatches++;
    if (mismatches <= 100) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  // selection of one object: returns 1 when it yields a beat
  function automatic bit predict_selection(input logic [31:0] word, input logic [2:0] pos,
                                           input logic last, output offer_res_t res);
    longint mv;
    longint ma;
    longint w;
    longint q;
    bit     usable;
    mv = 0;
    ma = 0;
    w = 0;
    usable = 1'b0;
    res = NO_MATCH;
    if (pos == 3'd0) begin
      list_closed = 1'b0;
    end
    if (list_closed) begin
      return 1'b0;
    end
    case (pdo_kind_t'(word[31:30]))
      PDO_FIXED: begin
        mv = longint'(word[19:10]) * 50;
        ma = longint'(word[9:0]) * 10;
        w = mv * ma / 1000000;
        usable = 1'b1;
      end
      PDO_BATTERY: begin
        mv = longint'(word[29:20]) * 50;
        w = longint'(word[9:0]) / 4;
        if (mv != 0) begin
          q = w * 1000 / mv;
          ma = (q > AMP_CAP_MA) ? AMP_CAP_MA : q;
        end
        usable = 1'b1;
      end
      default: usable = 1'b0;
    endcase
    if (usable && pos < OFFER_SLOTS && watt_floor_q != 0 && watt_floor_q <= POWER_CAP_W &&
        w >= watt_floor_q && mv <= max_mv_q) begin
      res.found = 1'b1;
      res.sel = pos;
      res.mv = mv[15:0];
      res.ma = ma[13:0];
      res.w = w[9:0];
      list_closed = 1'b1;
      return 1'b1;
    end
    if (last) begin
      list_closed = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [31:0] fixed_pdo(input logic [9:0] v, input logic [9:0] c);
    return {PDO_FIXED, 10'd0, v, c};
  endfunction

  function automatic logic [31:0] battery_pdo(input logic [9:0] v, input logic [9:0] p);
    return {PDO_BATTERY, v, 10'd0, p};
  endfunction

  function automatic offer_res_t hit(input logic [2:0] sel, input logic [15:0] mv,
                                     input logic [13:0] ma, input logic [9:0] w);
    offer_res_t r;
    r.found = 1'b1;
    r.sel = sel;
    r.mv = mv;
    r.ma = ma;
    r.w = w;
    return r;
  endfunction

  task automatic add_probe(input logic [31:0] word, input logic [2:0] pos, input logic last,
                           input chk_t chk, input offer_res_t res);
    probe_t p;
    p.word = word;
    p.pos = pos;
    p.last = last;
    p.chk = chk;
    p.res = res;
    probes.push_back(p);
  endtask

  // random object, mostly plausible supply levels, rest of the bits random
  function automatic logic [31:0] rand_offer();
    logic [31:0] word;
    logic [9:0]  v;
    logic [9:0]  c;
    int          k;
    word = $urandom();
    v = $urandom_range(1) ? volts[$urandom_range(7)] : 10'($urandom());
    c = $urandom_range(1) ? amps[$urandom_range(7)] : 10'($urandom());
    k = $urandom_range(99);
    if (k < 45) begin
      word[31:30] = PDO_FIXED;
      word[19:10] = v;
      word[9:0] = c;
    end else if (k < 75) begin
      word[31:30] = PDO_BATTERY;
      word[29:20] = v;
    end else if (k < 87) begin
      word[31:30] = PDO_VARIABLE;
    end else begin
      word[31:30] = PDO_AUGMENTED;
    end
    return word;
  endfunction

  // offer one object beat and record what it should yield
  task automatic send_offer(input logic [31:0] word, input logic [2:0] pos, input logic last,
                            input chk_t chk, input offer_res_t typed);
    offer_res_t res;
    bit         yields;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      s_tdata <= {5'd0, 3'($urandom_range(7)), 32'($urandom())};
      s_tlast <= 1'($urandom_range(1));
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, pos, word};
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    offers_sent++;
    yields = predict_selection(word, pos, last, res);
    if (chk == CHK_TYPED) begin
      expected_offers.push_back(typed);
    end else if (chk == CHK_MODEL && yields) begin
      expected_offers.push_back(res);
    end
  endtask

  // one list: mostly well formed, some truncated or started late, some noise
  task automatic send_random_batch();
    int r;
    int len;
    int first;
    int stop;
    r = $urandom_range(99);
    len = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 4);
    if (r < 72) begin
      for (int i = 0; i < len; i++) begin
        send_offer(rand_offer(), 3'(i), i == len - 1, CHK_MODEL, NO_MATCH);
      end
    end else if (r < 82) begin
      for (int i = 0; i < len; i++) begin
        send_offer(rand_offer(), 3'(i), 1'b0, CHK_MODEL, NO_MATCH);
      end
    end else if (r < 88) begin
      first = $urandom_range(1, 7);
      stop = (first + len - 1 > 7) ? 7 : first + len - 1;
      for (int i = first; i <= stop; i++) begin
        send_offer(rand_offer(), 3'(i), i == stop, CHK_MODEL, NO_MATCH);
      end
    end else begin
      repeat ($urandom_range(1, 3)) begin
        send_offer($urandom(), 3'($urandom_range(7)), 1'($urandom_range(1)), CHK_MODEL,
                   NO_MATCH);
      end
    end
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_MIN_POWER) begin
      watt_floor_q = val[7:0];
    end else begin
      max_mv_q = val;
    end
  endtask

  // stop offering, wait for every pending beat, then let the pipeline empty
  task automatic drain_block();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (expected_offers.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_offers.size() != 0) begin
      note_error($sformatf("%0d selection beats never arrived", expected_offers.size()));
      expected_offers.delete();
    end
  endtask

  // result sink: random stalls, long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : result_monitor
    offer_res_t seen;
    offer_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen.found = m_tuser;
      seen.sel = m_tdata[2:0];
      seen.mv = m_tdata[18:3];
      seen.ma = m_tdata[32:19];
      seen.w = m_tdata[42:33];
      if (expected_offers.size() == 0) begin
        note_error("selection beat with nothing expected");
      end else begin
        want = expected_offers.pop_front();
        if (seen.found != want.found)
          note_error($sformatf("found %0d, want %0d", seen.found, want.found));
        if (seen.sel != want.sel)
          note_error($sformatf("selected_index %0d, want %0d", seen.sel, want.sel));
        if (seen.mv != want.mv)
          note_error($sformatf("voltage_mv %0d, want %0d", seen.mv, want.mv));
        if (seen.ma != want.ma)
          note_error($sformatf("current_ma %0d, want %0d", seen.ma, want.ma));
        if (seen.w != want.w)
          note_error($sformatf("power_w %0d, want %0d", seen.w, want.w));
      end
    end
  end

  // stimulus
  initial begin
    static logic [15:0] lim_w [PHASES] = '{16'd1, 16'd0, 16'd141, 16'd140, 16'd255, 16'd1,
                                           16'hA53C, 16'd45, 16'd27, 16'd100, 16'd1, 16'd1};
    static logic [15:0] lim_v [PHASES] = '{16'd20000, 16'd51150, 16'd51150, 16'd51150, 16'd0,
                                           16'd0, 16'd65535, 16'd20000, 16'd9000, 16'd48000,
                                           16'd0, 16'd0};
    int start;

    // reset limits: 1 W minimum, 20 V ceiling
    add_probe(fixed_pdo(10'd100, 10'd300), 3'd2, 1'b0, CHK_TYPED,     // search open after reset
              hit(3'd2, 16'd5000, 14'd3000, 10'd15));
    add_probe(fixed_pdo(10'd400, 10'd500), 3'd3, 1'b1, CHK_QUIET, NO_MATCH);  // search over
    add_probe(fixed_pdo(10'd100, 10'd19), 3'd0, 1'b0, CHK_QUIET, NO_MATCH);   // 0.95 W
    add_probe(fixed_pdo(10'd100, 10'd20), 3'd1, 1'b0, CHK_TYPED,              // exactly 1 W
              hit(3'd1, 16'd5000, 14'd200, 10'd1));
    add_probe(fixed_pdo(10'd400, 10'd500), 3'd0, 1'b0, CHK_TYPED,             // at the ceiling
              hit(3'd0, 16'd20000, 14'd5000, 10'd100));
    add_probe(fixed_pdo(10'd401, 10'd500), 3'd0, 1'b0, CHK_QUIET, NO_MATCH);  // just above
    add_probe(fixed_pdo(10'd1023, 10'd1023), 3'd1, 1'b0, CHK_QUIET, NO_MATCH);
    add_probe(32'h0000_0000, 3'd2, 1'b0, CHK_QUIET, NO_MATCH);
    add_probe(32'hBFFF_FFFF, 3'd3, 1'b0, CHK_QUIET, NO_MATCH);              // variable
    add_probe(32'hFFFF_FFFF, 3'd4, 1'b1, CHK_TYPED, NO_MATCH);              // augmented, end
    add_probe(fixed_pdo(10'd400, 10'd1023), 3'd0, 1'b1, CHK_TYPED,
              hit(3'd0, 16'd20000, 14'd10230, 10'd204));
    add_probe(battery_pdo(10'd0, 10'd1023), 3'd0, 1'b0, CHK_TYPED,          // zero voltage
              hit(3'd0, 16'd0, 14'd0, 10'd255));
    add_probe(battery_pdo(10'd100, 10'd40), 3'd0, 1'b0, CHK_MODEL, NO_MATCH);
    add_probe(battery_pdo(10'd401, 10'd1023), 3'd0, 1'b0, CHK_QUIET, NO_MATCH);
    add_probe(battery_pdo(10'd400, 10'd3), 3'd1, 1'b0, CHK_QUIET, NO_MATCH);
    add_probe(battery_pdo(10'd1023, 10'd1023), 3'd2, 1'b1, CHK_TYPED, NO_MATCH);
    // positions out of order, only zero restarts
    add_probe(fixed_pdo(10'd500, 10'd300), 3'd0, 1'b0, CHK_QUIET, NO_MATCH);
    add_probe(fixed_pdo(10'd450, 10'd100), 3'd6, 1'b0, CHK_QUIET, NO_MATCH);
    add_probe(battery_pdo(10'd240, 10'd200), 3'd3, 1'b0, CHK_MODEL, NO_MATCH);
    add_probe(fixed_pdo(10'd100, 10'd300), 3'd5, 1'b1, CHK_QUIET, NO_MATCH);
    add_probe(fixed_pdo(10'd180, 10'd300), 3'd7, 1'b1, CHK_MODEL, NO_MATCH);
    add_probe(fixed_pdo(10'd180, 10'd300), 3'd0, 1'b1, CHK_MODEL, NO_MATCH);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    foreach (probes[i]) begin
      send_offer(probes[i].word, probes[i].pos, probes[i].last, probes[i].chk, probes[i].res);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_block();
      if (ph >= 10) begin
        lim_w[ph] = 16'($urandom_range(1, POWER_CAP_W));
        lim_v[ph] = 16'($urandom_range(0, 51150));
      end
      write_reg(CFG_MIN_POWER, lim_w[ph]);
      write_reg(CFG_MAX_VOLTAGE, lim_v[ph]);
      cfg_valid <= 1'b0;
      calm = (ph == 3);
      // sink holds off while single-object lists keep coming
      if (ph == 7) begin
        hold_left = 400;
        repeat (40) send_offer(rand_offer(), 3'd0, 1'b1, CHK_MODEL, NO_MATCH);
      end
      start = offers_sent;
      while (offers_sent - start < PHASE_OFFERS) send_random_batch();
    end

    drain_block();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
